// File: hw/rtl/timed_lowest_free_server_allocator_macros.svh
// Assertion helpers for the server allocator checker.
`ifndef TIMED_LOWEST_FREE_SERVER_ALLOCATOR_MACROS_SVH
`define TIMED_LOWEST_FREE_SERVER_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define TLFSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tlfsa_pkg.sv
`default_nettype none

package tlfsa_pkg;

    localparam int TIME_W = 24;
    localparam int WANT_W = 7;
    localparam int DUR_W  = 16;
    localparam int BUSY_W = 25;
    localparam int SUM_W  = 12;
    localparam int ACT_W  = 7;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd64;

    // register index as seen on paddr[2]
    localparam logic REG_ACTIVE_SERVERS = 1'b0;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [WANT_W-1:0] servers_wanted;
        logic [DUR_W-1:0]  duration;
    } request_t;

    typedef struct packed {
        logic             granted;
        logic [SUM_W-1:0] id_sum;
    } result_t;

    typedef struct packed {
        logic clear;   // restart counters for a new word
        logic check;   // RAM read data is valid this cycle
        logic alloc;   // allocation pass (else counting pass)
    } unit_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/timed_lowest_free_server_allocator.sv
// Timed lowest-free server allocator.
// Request channel: present a request word with start high; it is taken at a
// clock edge where start is high and busy is low. Result channel: done
// strobes for one cycle with the result word; the receiver cannot stall it.
// One shared compare unit walks the busy-time RAM one server per cycle,
// first counting free servers, then, if enough are free, leasing the
// lowest-numbered ones. done rises when the block returns to idle, and
// busy falls in that same cycle, so a new request can be taken while
// done is shown. Requests are handled one at a time, the scan reading
// the busy-time RAM through its single read port.
// After reset the block clears the busy-time RAM, one entry per cycle,
// with busy high; active_servers returns to 64.
// The APB port holds active_servers at address 0; write it only while idle.
`default_nettype none

module timed_lowest_free_server_allocator
    import tlfsa_pkg::*;
#(
    parameter int NUM_SERVERS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire request_t    request,
    output logic             done,
    output result_t          result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int CNT_W = $clog2(NUM_SERVERS + 1);
    localparam int PW    = (CNT_W > ACT_W) ? CNT_W : ACT_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_ALLOC
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pidx_reg, pidx_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [TIME_W-1:0]  start_reg, start_next;
    logic [WANT_W-1:0]  want_reg, want_next;
    logic [BUSY_W-1:0]  end_reg, end_next;
    logic               done_reg, done_next;
    result_t            result_reg, result_next;
    logic [ACT_W-1:0]   active_reg;

    logic [CNT_W-1:0]   pool_n;
    logic [BUSY_W-1:0]  end_sum;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [BUSY_W-1:0]  ram_wdata;
    logic [BUSY_W-1:0]  ram_rdata;
    unit_ctl_t          ctl;
    logic               take;
    logic               refuse;
    logic [SUM_W-1:0]   sum;
    logic               cfg_wr;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_ACTIVE_SERVERS) ? 32'(active_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_wr && paddr[2] == REG_ACTIVE_SERVERS)
        begin
            active_reg <= pwdata[ACT_W-1:0];
        end
    end

    assign pool_n = (PW'(active_reg) > PW'(NUM_SERVERS)) ? CNT_W'(NUM_SERVERS)
                                                         : CNT_W'(active_reg);

    // start plus duration; the stored lease end is one less, saturating at zero
    assign end_sum = BUSY_W'(request.start_time) + BUSY_W'(request.duration);

    tlfsa_ram #(
        .WIDTH (BUSY_W),
        .DEPTH (NUM_SERVERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    tlfsa_unit #(
        .NUM_SERVERS (NUM_SERVERS)
    ) u_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .idx        (pidx_reg),
        .busy_val   (ram_rdata),
        .start_time (start_reg),
        .want       (want_reg),
        .take       (take),
        .refuse     (refuse),
        .sum        (sum)
    );

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        n_next      = n_reg;
        start_next  = start_reg;
        want_next   = want_reg;
        end_next    = end_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ctl         = '0;
        ram_we      = 1'b0;
        ram_waddr   = pidx_reg;
        ram_wdata   = end_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[IDX_W-1:0];
                ram_wdata = '0;
                ptr_next  = ptr_reg + CNT_W'(1);
                if (ptr_reg == CNT_W'(NUM_SERVERS - 1))
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    start_next = request.start_time;
                    want_next  = request.servers_wanted;
                    end_next   = (end_sum == '0) ? '0 : end_sum - BUSY_W'(1);
                    n_next     = pool_n;
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    ctl.clear  = 1'b1;
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT, ST_ALLOC:
            begin
                ctl.check = pend_reg;
                ctl.alloc = (state_reg == ST_ALLOC);
                ram_we    = take;
                pend_next = 1'b0;
                if (ptr_reg < n_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[IDX_W-1:0];
                    ptr_next  = ptr_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    ptr_next = '0;
                    if (state_reg == ST_ALLOC)
                    begin
                        result_next = '{granted: 1'b1, id_sum: sum};
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else if (refuse)
                    begin
                        result_next = '{granted: 1'b0, id_sum: '0};
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ALLOC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            ptr_reg    <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg   <= pidx_next;
        n_reg      <= n_next;
        start_reg  <= start_next;
        want_reg   <= want_next;
        end_reg    <= end_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tlfsa_ram.sv
`default_nettype none

module tlfsa_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 64
) (
    input  wire logic                                           clk,
    input  wire logic                                           we,
    input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]     waddr,
    input  wire logic [WIDTH-1:0]                               wdata,
    input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]     raddr,
    output logic      [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/tlfsa_unit.sv
`default_nettype none

module tlfsa_unit
    import tlfsa_pkg::*;
#(
    parameter int NUM_SERVERS = 64
) (
    input  wire logic                                               clk,
    input  wire logic                                               rst_n,
    input  wire unit_ctl_t                                          ctl,
    input  wire logic [$clog2((NUM_SERVERS > 1) ? NUM_SERVERS : 2)-1:0] idx,
    input  wire logic [BUSY_W-1:0]                                  busy_val,
    input  wire logic [TIME_W-1:0]                                  start_time,
    input  wire logic [WANT_W-1:0]                                  want,
    output logic                                                    take,
    output logic                                                    refuse,
    output logic      [SUM_W-1:0]                                   sum
);

    localparam int CNT_W = $clog2(NUM_SERVERS + 1);
    localparam int PW    = (CNT_W > WANT_W) ? CNT_W : WANT_W;
    localparam int AW    = (CNT_W > SUM_W) ? CNT_W : SUM_W;

    logic [CNT_W-1:0] free_reg, free_next;
    logic [CNT_W-1:0] taken_reg, taken_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             is_free;
    logic             room;

    // the one compare shared by both passes
    assign is_free = busy_val < {1'b0, start_time};
    assign room    = PW'(taken_reg) < PW'(want);
    assign take    = ctl.check && ctl.alloc && is_free && room;
    assign refuse  = PW'(want) > PW'(free_reg);
    assign sum     = sum_reg;

    always_comb
    begin
        free_next  = free_reg;
        taken_next = taken_reg;
        sum_next   = sum_reg;
        if (ctl.clear)
        begin
            free_next  = '0;
            taken_next = '0;
            sum_next   = '0;
        end
        else if (ctl.check && !ctl.alloc && is_free)
        begin
            free_next = free_reg + CNT_W'(1);
        end
        else if (take)
        begin
            taken_next = taken_reg + CNT_W'(1);
            sum_next   = sum_reg + SUM_W'(AW'(idx) + AW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg  <= '0;
            taken_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            free_reg  <= free_next;
            taken_reg <= taken_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tlfsa_checker.sv
`default_nettype none
`include "timed_lowest_free_server_allocator_macros.svh"

module tlfsa_checker
    import tlfsa_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     done,
    input wire result_t  result,
    input wire logic     pready
);

    `TLFSA_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy, "done while busy")
    `TLFSA_ASSERT_NOW(a_refuse_zero, clk, rst_n, done && !result.granted, result.id_sum == '0, "refused word has nonzero id_sum")
    `TLFSA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted word did not raise busy")
    `TLFSA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done longer than one cycle")
    `TLFSA_ASSERT_NOW(a_pready, clk, rst_n, 1'b1, pready, "pready low")

endmodule

bind timed_lowest_free_server_allocator tlfsa_checker u_tlfsa_checker (.*);

`default_nettype wire

// File: sim/tb_timed_lowest_free_server_allocator.sv
`default_nettype none

module tb_timed_lowest_free_server_allocator;
    import tlfsa_pkg::*;

    localparam int SERVERS      = 64;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int TOP_TIME     = 16777215;
    localparam int NDIR         = 21;
    localparam int NPHASE       = 7;

    // pool size per random phase, and words sent in each
    localparam int PH_POOL  [NPHASE] = '{64, 1, 7, 127, 0, 33, 64};
    localparam int PH_ITEMS [NPHASE] = '{250, 120, 200, 200, 40, 200, 240};

    typedef struct packed {
        bit               wr;      // program pool size before this word
        logic [ACT_W-1:0] pool;
        request_t         rq;
        bit               typed;   // expected word given in the row
        result_t          res;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [NDIR] = '{
        '{1'b0, 7'd0,   '{24'd1,        7'd1,   16'd1},     1'b1, '{1'b1, 12'd1}},
        '{1'b0, 7'd0,   '{24'd1,        7'd1,   16'd1},     1'b1, '{1'b1, 12'd2}},
        '{1'b0, 7'd0,   '{24'd0,        7'd0,   16'd0},     1'b1, '{1'b1, 12'd0}},
        '{1'b0, 7'd0,   '{24'd0,        7'd1,   16'd3},     1'b1, '{1'b0, 12'd0}},
        '{1'b0, 7'd0,   '{24'd16777215, 7'd0,   16'd65535}, 1'b1, '{1'b1, 12'd0}},
        '{1'b0, 7'd0,   '{24'd16777215, 7'd127, 16'd65535}, 1'b1, '{1'b0, 12'd0}},
        '{1'b0, 7'd0,   '{24'd16777215, 7'd65,  16'd0},     1'b1, '{1'b0, 12'd0}},
        '{1'b0, 7'd0,   '{24'd2,        7'd64,  16'd65535}, 1'b1, '{1'b1, 12'd2080}},
        '{1'b0, 7'd0,   '{24'd65536,    7'd1,   16'd1},     1'b1, '{1'b0, 12'd0}},
        '{1'b0, 7'd0,   '{24'd3,        7'd1,   16'd1},     1'b1, '{1'b0, 12'd0}},
        '{1'b0, 7'd0,   '{24'd65537,    7'd3,   16'd2},     1'b0, '{1'b0, 12'd0}},
        '{1'b0, 7'd0,   '{24'd65538,    7'd2,   16'd10},    1'b0, '{1'b0, 12'd0}},
        '{1'b1, 7'd1,   '{24'd65600,    7'd1,   16'd1},     1'b1, '{1'b1, 12'd1}},
        '{1'b0, 7'd0,   '{24'd65600,    7'd1,   16'd1},     1'b1, '{1'b0, 12'd0}},
        '{1'b1, 7'd0,   '{24'd70000,    7'd1,   16'd1},     1'b1, '{1'b0, 12'd0}},
        '{1'b0, 7'd0,   '{24'd70000,    7'd0,   16'd1},     1'b1, '{1'b1, 12'd0}},
        '{1'b1, 7'd127, '{24'd70001,    7'd64,  16'd5},     1'b1, '{1'b1, 12'd2080}},
        '{1'b0, 7'd0,   '{24'd70006,    7'd65,  16'd1},     1'b1, '{1'b0, 12'd0}},
        '{1'b1, 7'd2,   '{24'd70006,    7'd2,   16'd1},     1'b1, '{1'b1, 12'd3}},
        '{1'b0, 7'd0,   '{24'd70007,    7'd2,   16'd32768}, 1'b0, '{1'b0, 12'd0}},
        '{1'b1, 7'd64,  '{24'd70008,    7'd40,  16'd7},     1'b0, '{1'b0, 12'd0}}
    };

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    request_t    request;
    logic        done;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // mirror of the block: last busy step per server and the pool size
    logic [BUSY_W-1:0] srv_last_busy [SERVERS];
    int unsigned       pool_setting;
    result_t           awaited_results [$];

    int n_err;
    int n_sent;
    int n_granted;
    int n_refused;
    int n_cfg;
    int n_cycles;

    timed_lowest_free_server_allocator #(
        .NUM_SERVERS(SERVERS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned pool_in_use();
        return (pool_setting > SERVERS) ? SERVERS : pool_setting;
    endfunction

    // queue one expected result word at the tail
    function automatic void append_expected(input result_t w);
        awaited_results = {awaited_results, w};
    endfunction

    // lease the lowest-numbered free servers, or refuse with no change
    function automatic result_t lease_lowest_free(request_t rq);
        int unsigned       pool;
        int unsigned       nfree;
        int unsigned       taken;
        int unsigned       idsum;
        logic [BUSY_W-1:0] lease_end;
        result_t           r;
        pool  = pool_in_use();
        nfree = 0;
        taken = 0;
        idsum = 0;
        r     = '0;
        for (int i = 0; i < pool; i++)
            if (srv_last_busy[i] < rq.start_time)
                nfree++;
        if (rq.servers_wanted > nfree)
            return r;
        lease_end = {1'b0, rq.start_time} + BUSY_W'(rq.duration);
        if (lease_end != '0)
            lease_end = lease_end - 1'b1;
        for (int i = 0; i < pool && taken < rq.servers_wanted; i++)
        begin
            if (srv_last_busy[i] < rq.start_time)
            begin
                srv_last_busy[i] = lease_end;
                idsum += i + 1;
                taken++;
            end
        end
        r.granted = 1'b1;
        r.id_sum  = SUM_W'(idsum);
        return r;
    endfunction

    task automatic issue(input request_t rq, input bit typed, input result_t typed_res);
        result_t p;
        @(negedge clk);
        start   <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = lease_lowest_free(rq);
        append_expected(typed ? typed_res : p);
        n_sent++;
    endtask

    // sender gap after a word, sized to land anywhere in the block's scan
    task automatic maybe_rest(input bit calm);
        int gap;
        if (!calm && $urandom_range(0, 99) < 36)
        begin
            gap = $urandom_range(1, 2 * pool_in_use() + 8);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    // write the pool size, then read it back
    task automatic set_pool(input logic [ACT_W-1:0] v);
        logic [31:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ACTIVE_SERVERS, 2'b00};
        pwdata  <= 32'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        pool_setting = v;
        n_cfg++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== 32'(v))
        begin
            n_err++;
            $display("%0t: pool size readback expected %0d, got %0d", $time, v, rd);
        end
    endtask

    always @(posedge clk)
    begin
        result_t exp_word;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                n_err++;
                $display("%0t: result word with none expected: granted=%0d id_sum=%0d",
                         $time, result.granted, result.id_sum);
            end
            else
            begin
                exp_word = awaited_results.pop_front();
                if (result.granted !== exp_word.granted)
                begin
                    n_err++;
                    $display("%0t: granted expected %0d, got %0d",
                             $time, exp_word.granted, result.granted);
                end
                if (result.id_sum !== exp_word.id_sum)
                begin
                    n_err++;
                    $display("%0t: id_sum expected %0d, got %0d",
                             $time, exp_word.id_sum, result.id_sum);
                end
                if (result.granted === 1'b1)
                    n_granted++;
                else
                    n_refused++;
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > LIMIT_CYCLES)
        begin
            $display("[timed_lowest_free_server_allocator] ERROR");
            $finish;
        end
    end

    initial
    begin
        request_t    rq;
        int unsigned cursor;
        int unsigned t;
        int unsigned base;
        int unsigned pe;
        int          sel;
        int          k;
        int          seq;

        rst_n    = 1'b0;
        start    = 1'b0;
        request  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        n_err     = 0;
        n_sent    = 0;
        n_granted = 0;
        n_refused = 0;
        n_cfg     = 0;
        n_cycles  = 0;
        seq       = 0;
        pool_setting = ACTIVE_RESET;
        for (int i = 0; i < SERVERS; i++)
            srv_last_busy[i] = '0;

        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words; issue waits out the clearing pass
        for (int r = 0; r < NDIR; r++)
        begin
            if (DIR_ROWS[r].wr)
            begin
                wait_idle();
                set_pool(DIR_ROWS[r].pool);
            end
            issue(DIR_ROWS[r].rq, DIR_ROWS[r].typed, DIR_ROWS[r].res);
            maybe_rest(1'b0);
        end

        cursor = 70008;
        for (int ph = 0; ph < NPHASE; ph++)
        begin
            wait_idle();
            set_pool(ACT_W'(PH_POOL[ph]));
            pe   = pool_in_use();
            // each phase climbs to a higher time so all start bits toggle
            base = (ph == NPHASE - 1) ? TOP_TIME - 4000 : 100000 + ph * 2300000;
            if (cursor < base)
                cursor = base;
            for (k = 0; k < PH_ITEMS[ph]; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 30)
                    ;
                else if (sel < 33 && ph != NPHASE - 1)
                    cursor += $urandom_range(1000, 100000);
                else
                    cursor += $urandom_range(1, 12);
                if (cursor > TOP_TIME)
                    cursor = TOP_TIME;
                t   = cursor;
                sel = $urandom_range(0, 99);
                if (sel < 4 && cursor > 300)
                    t = cursor - $urandom_range(1, 300);   // out of order
                else if (sel < 5)
                    t = 0;
                rq.start_time = TIME_W'(t);

                sel = $urandom_range(0, 99);
                if (sel < 8)
                    rq.servers_wanted = '0;
                else if (sel < 16)
                    rq.servers_wanted = WANT_W'($urandom_range(0, 127));
                else if (sel < 28)
                    rq.servers_wanted = WANT_W'($urandom_range(1, (pe > 0) ? pe : 1));
                else
                    rq.servers_wanted = WANT_W'($urandom_range(1, pe / 4 + 1));

                sel = $urandom_range(0, 99);
                if (sel < 4)
                    rq.duration = '0;
                else if (sel < 9)
                    rq.duration = DUR_W'($urandom_range(0, 65535));
                else if (sel < 20)
                    rq.duration = DUR_W'($urandom_range(41, 400));
                else
                    rq.duration = DUR_W'($urandom_range(1, 40));

                issue(rq, 1'b0, '0);
                // back-to-back stretch with no sender gaps
                maybe_rest(seq >= 400 && seq < 600);
                seq++;
            end
        end

        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (2 * SERVERS + 10)
            @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            n_err++;
            $display("%0t: %0d result words never arrived", $time, awaited_results.size());
        end

        $display("Sent %0d requests over %0d pool sizes (0, 1, 64, above 64 among them);",
                 n_sent, n_cfg);
        $display("%0d leases granted, %0d refused, %0d mismatches.",
                 n_granted, n_refused, n_err);
        if (n_err == 0)
            $display("[timed_lowest_free_server_allocator] OK");
        else
            $display("[timed_lowest_free_server_allocator] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/tlfsa_pkg.sv
hw/rtl/tlfsa_ram.sv
hw/rtl/tlfsa_unit.sv
hw/rtl/timed_lowest_free_server_allocator.sv
hw/rtl/tlfsa_checker.sv
sim/tb_timed_lowest_free_server_allocator.sv
